[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the TV-out top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define TVO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define TVO_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/tvo_pkg.sv]
// ----------------------------------------------------------------------------
// tvo_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package tvo_pkg;

  localparam int BANK_BYTES      = 256;
  localparam int WORDS_PER_BANK  = BANK_BYTES / 4;
  localparam int WORD_W          = $clog2(WORDS_PER_BANK);
  localparam int STORE_DEPTH     = 3 * WORDS_PER_BANK;
  localparam int ADDR_W          = $clog2(STORE_DEPTH);
  // offset + count must fit for the range check
  localparam int LIM_W           = (BANK_BYTES > 256) ? $clog2(BANK_BYTES) + 1 : 9;

  localparam int ENC_STATUS_WORD = 1;
  localparam int ENC_MASK_WORD   = 2;
  localparam int MIX_STATUS_WORD = 1;
  localparam int VSYNC_MASK_BIT  = 0;

  localparam bit ENC_STATUS_OK   = (ENC_STATUS_WORD < WORDS_PER_BANK);
  localparam bit ENC_MASK_OK     = (ENC_MASK_WORD < WORDS_PER_BANK);
  localparam bit MIX_STATUS_OK   = (MIX_STATUS_WORD < WORDS_PER_BANK);
  localparam logic [WORD_W-1:0] ENC_STATUS_IDX = WORD_W'(ENC_STATUS_WORD);
  localparam logic [WORD_W-1:0] ENC_MASK_IDX   = WORD_W'(ENC_MASK_WORD);
  localparam logic [WORD_W-1:0] MIX_STATUS_IDX = WORD_W'(MIX_STATUS_WORD);

  localparam logic [31:0] PERIOD_RESET = 32'd400000;

  // 33-bit dividend (phase + ticks), one quotient bit per step
  localparam int DIV_STEPS = 33;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    ACT_READ,
    ACT_WRITE,
    ACT_TICK,
    ACT_NONE
  } act_t;

  typedef enum logic [1:0] {
    BANK_CTRL,
    BANK_MIX,
    BANK_ENC,
    BANK_BAD
  } bank_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEC,
    ST_RD_A,
    ST_CAP_A,
    ST_CAP_B,
    ST_WR_A,
    ST_RD_B,
    ST_WR_B,
    ST_DIV,
    ST_DIV_END,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_a;
    logic rd_b;
    logic cap_a;
    logic cap_b;
    logic wr_a;
    logic wr_b;
    logic div_step;
    logic div_end;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    act_t act;
    logic acc_ok;
    logic need_b;
    logic tick_go;
    logic div_last;
    logic out_free;
  } dp_sts_t;

endpackage

[rtl/core/tvo_ram.sv]
// ----------------------------------------------------------------------------
// tvo_ram
// Generic single-port RAM, registered read.
// ----------------------------------------------------------------------------
module tvo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[rtl/core/tvo_dp.sv]
// ----------------------------------------------------------------------------
// tvo_dp
// Datapath: request latch, register store with byte-lane merge, frame timer
// with serial divider, and the result register.
// ----------------------------------------------------------------------------
module tvo_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  tvo_pkg::dp_cmd_t  cmd,
  output tvo_pkg::dp_sts_t  sts,
  input  logic [1:0]        in_action,
  input  logic [1:0]        in_bank,
  input  logic [7:0]        in_byte_offset,
  input  logic [2:0]        in_byte_count,
  input  logic [31:0]       in_write_data,
  input  logic [31:0]       in_tick_count,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_frame_period,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_read_data,
  output logic              out_access_error,
  output logic              out_irq_out,
  output logic              out_is_running,
  output logic [31:0]       out_ticks_to_vsync,
  output logic [31:0]       out_frame_total
);

  import tvo_pkg::*;

  // latched request
  act_t        act_r;
  bank_t       bank_r;
  logic [7:0]  off_r;
  logic [2:0]  count_r;
  logic [31:0] wdata_r;
  logic        was_run_r;

  // bits that live in flops; the RAM copy of these positions is ignored
  logic [2:0]  run_r;
  logic        pend_r;
  logic        mask_r;

  logic [31:0] period_r;
  logic [31:0] phase_r;
  logic [31:0] frames_r;

  // divider
  logic [32:0]          quo_r;
  logic [31:0]          rem_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [32:0]          rem_sh;
  logic [32:0]          rem_diff;
  logic                 rem_ge;

  // store
  logic [STORE_DEPTH-1:0] vld_r;
  logic                   rd_vld_r;
  logic [31:0]            ram_rdata;
  logic                   ram_we;
  logic                   ram_re;
  logic [ADDR_W-1:0]      ram_addr;
  logic [ADDR_W-1:0]      base;
  logic [8:0]             word_a_w;
  logic [8:0]             word_b_w;
  logic [WORD_W-1:0]      word_a;
  logic [WORD_W-1:0]      word_b;
  logic [WORD_W-1:0]      aword;
  logic [WORD_W-1:0]      dword;
  logic                   asel;
  logic                   dsel;

  logic [31:0] raw;
  logic [31:0] vis;
  logic [31:0] new_word;
  logic        run_bank;
  logic        is_enc_status;
  logic        is_enc_mask;
  logic        is_w1c;

  logic [3:0]  cmask;
  logic [7:0]  lane8;
  logic [63:0] lane64;
  logic [63:0] data64;
  logic [31:0] lanes32;
  logic [31:0] val32;
  logic [31:0] lo_r;
  logic [31:0] hi_r;
  logic [63:0] win64;
  logic [31:0] cmask32;
  logic [31:0] rd_asm;

  logic [LIM_W-1:0] lim;
  logic             acc_ok;
  logic             need_b;
  logic             running;
  logic             tick_go;
  logic             clr_phase;
  logic [31:0]      phase_eff;
  logic             irq;
  logic [31:0]      ticks_left;
  logic             out_valid_r;
  logic             out_free;

  // ---------------- request decode ----------------
  always_comb begin
    unique case (count_r)
      3'd1:    cmask = 4'b0001;
      3'd2:    cmask = 4'b0011;
      3'd4:    cmask = 4'b1111;
      default: cmask = 4'b0000;
    endcase
  end

  assign lim    = LIM_W'(off_r) + LIM_W'(count_r);
  assign acc_ok = (bank_r != BANK_BAD) && (cmask != 4'b0000) &&
                  (lim <= LIM_W'(BANK_BYTES));
  assign need_b = ({2'b00, off_r[1:0]} + {1'b0, count_r}) > 4'd4;

  assign running = &run_r;
  assign tick_go = running && (period_r != 32'd0);

  assign word_a_w = {3'b000, off_r[7:2]};
  assign word_b_w = word_a_w + 9'd1;
  assign word_a   = WORD_W'(word_a_w);
  assign word_b   = WORD_W'(word_b_w);

  // address side follows the issuing state, data side the word now in rdata
  assign asel  = cmd.rd_b | cmd.wr_b;
  assign dsel  = cmd.cap_b | cmd.wr_b;
  assign aword = asel ? word_b : word_a;
  assign dword = dsel ? word_b : word_a;

  assign base     = ADDR_W'(32'(bank_r) * WORDS_PER_BANK);
  assign ram_addr = base + ADDR_W'(aword);
  assign ram_re   = cmd.rd_a | cmd.rd_b;
  assign ram_we   = cmd.wr_a | cmd.wr_b;

  tvo_ram #(
    .WIDTH (32),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (new_word),
    .rdata (ram_rdata)
  );

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ram_we) begin
      vld_r[ram_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_vld_r <= vld_r[ram_addr];
    end
  end

  assign raw = rd_vld_r ? ram_rdata : 32'd0;

  // ---------------- word merge ----------------
  always_comb begin
    unique case (bank_r)
      BANK_CTRL: run_bank = run_r[0];
      BANK_MIX:  run_bank = run_r[1];
      BANK_ENC:  run_bank = run_r[2];
      default:   run_bank = 1'b0;
    endcase
  end

  assign is_enc_status = ENC_STATUS_OK && (bank_r == BANK_ENC) && (dword == ENC_STATUS_IDX);
  assign is_enc_mask   = ENC_MASK_OK && (bank_r == BANK_ENC) && (dword == ENC_MASK_IDX);
  assign is_w1c        = is_enc_status ||
                         (MIX_STATUS_OK && (bank_r == BANK_MIX) && (dword == MIX_STATUS_IDX));

  always_comb begin
    vis = raw;
    if (dword == '0) begin
      vis[0] = run_bank;
      vis[1] = ~run_bank;
    end
    if (is_enc_status) begin
      vis[0] = pend_r;
    end
    if (is_enc_mask) begin
      vis[VSYNC_MASK_BIT] = mask_r;
    end
  end

  assign lane8  = {4'b0000, cmask} << off_r[1:0];
  assign data64 = {32'd0, wdata_r} << {off_r[1:0], 3'b000};

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      lane64[8*k +: 8] = {8{lane8[k]}};
    end
    for (int k = 0; k < 4; k++) begin
      cmask32[8*k +: 8] = {8{cmask[k]}};
    end
  end

  assign lanes32 = dsel ? lane64[63:32] : lane64[31:0];
  assign val32   = (dsel ? data64[63:32] : data64[31:0]) & lanes32;

  always_comb begin
    if (is_w1c) begin
      new_word = vis & ~val32;
    end else begin
      new_word = (vis & ~lanes32) | val32;
    end
    // ready bit is never stored
    if (dword == '0) begin
      new_word[1] = 1'b0;
    end
  end

  assign win64  = {hi_r, lo_r} >> {off_r[1:0], 3'b000};
  assign rd_asm = win64[31:0] & cmask32;

  always_ff @(posedge clk) begin
    if (cmd.cap_a) begin
      lo_r <= vis;
    end
    if (cmd.cap_b) begin
      hi_r <= vis;
    end
  end

  // ---------------- request latch ----------------
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r     <= act_t'(in_action);
      bank_r    <= bank_t'(in_bank);
      off_r     <= in_byte_offset;
      count_r   <= in_byte_count;
      wdata_r   <= in_write_data;
      was_run_r <= running;
    end
  end

  // ---------------- divider ----------------
  assign rem_sh   = {rem_r, quo_r[32]};
  assign rem_diff = rem_sh - {1'b0, period_r};
  assign rem_ge   = rem_sh >= {1'b0, period_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo_r <= {1'b0, phase_r} + {1'b0, in_tick_count};
      rem_r <= 32'd0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[31:0], rem_ge};
      rem_r <= rem_ge ? rem_diff[31:0] : rem_sh[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + DIV_CNT_W'(1);
    end
  end

  // ---------------- timer state and flop bits ----------------
  assign clr_phase = ((act_r == ACT_TICK) && !tick_go) ||
                     ((act_r == ACT_WRITE) && acc_ok && (was_run_r != running));
  assign phase_eff = clr_phase ? 32'd0 : phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r    <= 3'b000;
      pend_r   <= 1'b0;
      mask_r   <= ENC_MASK_OK;
      period_r <= PERIOD_RESET;
      phase_r  <= 32'd0;
      frames_r <= 32'd0;
    end else begin
      if (cfg_wr_en) begin
        period_r <= cfg_frame_period;
      end
      if (ram_we) begin
        if (dword == '0) begin
          unique case (bank_r)
            BANK_CTRL: run_r[0] <= new_word[0];
            BANK_MIX:  run_r[1] <= new_word[0];
            BANK_ENC:  run_r[2] <= new_word[0];
            default:   run_r    <= run_r;
          endcase
        end
        if (is_enc_status) begin
          pend_r <= new_word[0];
        end
        if (is_enc_mask) begin
          mask_r <= new_word[VSYNC_MASK_BIT];
        end
      end
      if (cmd.div_end) begin
        phase_r  <= rem_r;
        frames_r <= frames_r + quo_r[31:0];
        if (ENC_STATUS_OK && (quo_r != 33'd0)) begin
          pend_r <= 1'b1;
        end
      end
      if (cmd.finish) begin
        phase_r <= phase_eff;
      end
    end
  end

  // ---------------- result register ----------------
  assign irq = running && pend_r && !mask_r;

  always_comb begin
    if (!tick_go || irq || mask_r) begin
      ticks_left = 32'd0;
    end else if (phase_eff < period_r) begin
      ticks_left = period_r - phase_eff;
    end else begin
      ticks_left = 32'd1;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_read_data      <= ((act_r == ACT_READ) && acc_ok) ? rd_asm : 32'd0;
      out_access_error   <= ((act_r == ACT_READ) || (act_r == ACT_WRITE)) && !acc_ok;
      out_irq_out        <= irq;
      out_is_running     <= running;
      out_ticks_to_vsync <= ticks_left;
      out_frame_total    <= frames_r;
    end
  end

  assign out_valid = out_valid_r;

  assign sts.act      = act_r;
  assign sts.acc_ok   = acc_ok;
  assign sts.need_b   = need_b;
  assign sts.tick_go  = tick_go;
  assign sts.div_last = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  assign sts.out_free = out_free;

endmodule

[rtl/core/tvo_ctrl.sv]
// ----------------------------------------------------------------------------
// tvo_ctrl
// Sequencer: decode, store read/modify/write steps, divider steps, result.
// ----------------------------------------------------------------------------
module tvo_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tvo_pkg::dp_sts_t  sts,
  output tvo_pkg::dp_cmd_t  cmd
);

  import tvo_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DEC;
      end
      ST_DEC: begin
        unique case (sts.act) inside
          ACT_READ, ACT_WRITE: state_nxt = sts.acc_ok ? ST_RD_A : ST_FIN;
          ACT_TICK:            state_nxt = sts.tick_go ? ST_DIV : ST_FIN;
          default:             state_nxt = ST_FIN;
        endcase
      end
      ST_RD_A:    state_nxt = (sts.act == ACT_WRITE) ? ST_WR_A : ST_CAP_A;
      ST_CAP_A:   state_nxt = sts.need_b ? ST_CAP_B : ST_FIN;
      ST_CAP_B:   state_nxt = ST_FIN;
      ST_WR_A:    state_nxt = sts.need_b ? ST_RD_B : ST_FIN;
      ST_RD_B:    state_nxt = ST_WR_B;
      ST_WR_B:    state_nxt = ST_FIN;
      ST_DIV:     state_nxt = sts.div_last ? ST_DIV_END : ST_DIV;
      ST_DIV_END: state_nxt = ST_FIN;
      ST_FIN: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_RD_A:    cmd.rd_a = 1'b1;
      ST_CAP_A: begin
        cmd.cap_a = 1'b1;
        cmd.rd_b  = sts.need_b;
      end
      ST_CAP_B:   cmd.cap_b    = 1'b1;
      ST_WR_A:    cmd.wr_a     = 1'b1;
      ST_RD_B:    cmd.rd_b     = 1'b1;
      ST_WR_B:    cmd.wr_b     = 1'b1;
      ST_DIV:     cmd.div_step = 1'b1;
      ST_DIV_END: cmd.div_end  = 1'b1;
      ST_FIN:     cmd.finish   = sts.out_free;
      default:    cmd          = '0;
    endcase
  end

endmodule

[rtl/core/tv_output_register_and_vsync_timer.sv]
// ----------------------------------------------------------------------------
// tv_output_register_and_vsync_timer
// TV-out register banks (control, mixer, encoder) with a VSYNC frame timer.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------------
//   in_     | in        | in_valid/in_ready  | action, bank, offset, count, data, ticks
//   out_    | out       | out_valid/out_ready| read data, error, irq, run, ticks
//   cfg_    | in        | cfg_wr_en          | frame period
//
// One request at a time. An invalid access, unused action or stopped tick goes
// from decode straight to the result; a read reads and captures each spanned word;
// a write reads and writes each spanned word in turn; a running tick steps the
// restoring divider, which yields one of 33 quotient bits per cycle.
// The store is one single-port RAM; each spanned word costs a read, plus a write
// for a write request.
// Synchronous reset, no clearing pass. A result waiting in the output register
// does not block acceptance; the next result waits for that slot.
// ----------------------------------------------------------------------------
module tv_output_register_and_vsync_timer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [1:0]  in_bank,
  input  logic [7:0]  in_byte_offset,
  input  logic [2:0]  in_byte_count,
  input  logic [31:0] in_write_data,
  input  logic [31:0] in_tick_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data,
  output logic        out_access_error,
  output logic        out_irq_out,
  output logic        out_is_running,
  output logic [31:0] out_ticks_to_vsync,
  output logic [31:0] out_frame_total,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_frame_period
);

  import tvo_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  tvo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tvo_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_action          (in_action),
    .in_bank            (in_bank),
    .in_byte_offset     (in_byte_offset),
    .in_byte_count      (in_byte_count),
    .in_write_data      (in_write_data),
    .in_tick_count      (in_tick_count),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_frame_period   (cfg_frame_period),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_data      (out_read_data),
    .out_access_error   (out_access_error),
    .out_irq_out        (out_irq_out),
    .out_is_running     (out_is_running),
    .out_ticks_to_vsync (out_ticks_to_vsync),
    .out_frame_total    (out_frame_total)
  );

`include "assert_macros.svh"

  `TVO_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "accepted twice")
  `TVO_ASSERT(a_err_no_data, (out_valid && out_access_error) |-> (out_read_data == 32'd0), "error with data")
  `TVO_ASSERT(a_irq_running, (out_valid && out_irq_out) |-> out_is_running, "irq while stopped")
  `TVO_ASSERT(a_ticks_gate, (out_valid && (out_ticks_to_vsync != 32'd0)) |-> (out_is_running && !out_irq_out), "ticks while idle or pending")
  `TVO_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result after reset")

endmodule

[tb/tv_output_register_and_vsync_timer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tv_output_register_and_vsync_timer_tb
// Self-checking bench for the TV-out register banks and the VSYNC frame timer.
//
// A scoreboard class carries its own copy of the three banks, the frame phase,
// the frame count and the frame period. Every accepted request is run through
// it, and every accepted result is checked field by field against the oldest
// pending prediction. A directed pass covers access errors, unaligned and
// split accesses, the ready and write-one-to-clear bits, the run state and
// VSYNC. Random passes follow under several frame periods, zero and the
// 32-bit extremes among them. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tv_output_register_and_vsync_timer_tb;
  import tvo_pkg::*;

  localparam int          BANK_SPAN  = 256;
  localparam int          BANK_WORDS = BANK_SPAN / 4;
  localparam int          ENC_STAT_W = 1;
  localparam int          ENC_MASK_W = 2;
  localparam int          MIX_STAT_W = 1;
  localparam logic [31:0] MASK_FLAG  = 32'h1;  // VSYNC mask bit 0
  localparam logic [31:0] RUN_FLAG   = 32'h1;
  localparam logic [31:0] READY_FLAG = 32'h2;
  localparam logic [31:0] PEND_FLAG  = 32'h1;
  localparam int          PHASE_REQS = 200;
  localparam int          SETTLE     = 40;

  typedef struct packed {
    act_t        action;
    bank_t       bank;
    logic [7:0]  offset;
    logic [2:0]  count;
    logic [31:0] write_data;
    logic [31:0] tick_count;
  } request_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        access_error;
    logic        irq;
    logic        running;
    logic [31:0] ticks_left;
    logic [31:0] frame_total;
  } report_t;

  class tvo_frame_scoreboard;
    logic [31:0] regs [3*BANK_WORDS];
    logic [31:0] phase;
    logic [31:0] frames;
    logic [31:0] frame_period;
    report_t     pending_reports[$];
    int          failures;

    function new();
      foreach (regs[k]) regs[k] = '0;
      regs[int'(BANK_ENC)*BANK_WORDS + ENC_MASK_W] = MASK_FLAG;
      phase        = '0;
      frames       = '0;
      frame_period = 32'd400000;
      failures     = 0;
    endfunction

    function logic [31:0] word_at(int b, int w);
      if (b > 2 || w >= BANK_WORDS) return '0;
      return regs[b*BANK_WORDS + w];
    endfunction

    function bit is_running_now();
      return (word_at(int'(BANK_CTRL), 0) & RUN_FLAG) != 0 &&
             (word_at(int'(BANK_MIX), 0) & RUN_FLAG) != 0 &&
             (word_at(int'(BANK_ENC), 0) & RUN_FLAG) != 0;
    endfunction

    function bit vsync_masked();
      return (word_at(int'(BANK_ENC), ENC_MASK_W) & MASK_FLAG) != 0;
    endfunction

    function bit irq_now();
      return is_running_now() && !vsync_masked() &&
             (word_at(int'(BANK_ENC), ENC_STAT_W) & PEND_FLAG) != 0;
    endfunction

    function logic [31:0] ticks_to_next_frame();
      if (!is_running_now() || frame_period == 0 || irq_now() || vsync_masked())
        return '0;
      return (phase < frame_period) ? frame_period - phase : 32'd1;
    endfunction

    // word 0 shows ready in place of the stored bit 1
    function logic [31:0] shown(int b, int w);
      logic [31:0] v;
      v = word_at(b, w);
      if (w == 0) begin
        v &= ~READY_FLAG;
        if ((v & RUN_FLAG) == 0) v |= READY_FLAG;
      end
      return v;
    endfunction

    function void apply_write(int b, int off, int cnt, logic [31:0] data);
      bit          was;
      int          at;
      int          w;
      logic [31:0] lane;
      logic [31:0] val;
      was = is_running_now();
      for (int i = 0; i < cnt; i++) begin
        at   = off + i;
        w    = at >> 2;
        lane = 32'hFF << ((at % 4) * 8);
        val  = ((data >> (i * 8)) & 32'hFF) << ((at % 4) * 8);
        if (w < BANK_WORDS) begin
          if ((b == int'(BANK_ENC) && w == ENC_STAT_W) ||
              (b == int'(BANK_MIX) && w == MIX_STAT_W)) begin
            regs[b*BANK_WORDS + w] &= ~val;
          end else begin
            regs[b*BANK_WORDS + w] = (regs[b*BANK_WORDS + w] & ~lane) | val;
            if (w == 0) regs[b*BANK_WORDS] &= ~READY_FLAG;
          end
        end
      end
      if (was != is_running_now()) phase = '0;
    endfunction

    function void advance_frames(logic [31:0] ticks);
      logic [63:0] total;
      logic [63:0] done;
      if (!is_running_now() || frame_period == 0) begin
        phase = '0;
        return;
      end
      total = {32'b0, phase} + {32'b0, ticks};
      done  = total / {32'b0, frame_period};
      phase = 32'(total % {32'b0, frame_period});
      if (done != 0) begin
        frames += done[31:0];
        regs[int'(BANK_ENC)*BANK_WORDS + ENC_STAT_W] |= PEND_FLAG;
      end
    endfunction

    function report_t compute_report(request_t r);
      report_t rep;
      int      b;
      int      off;
      int      cnt;
      int      at;
      bit      legal;
      rep   = '0;
      b     = int'(r.bank);
      off   = int'(r.offset);
      cnt   = int'(r.count);
      legal = b <= 2 && (cnt == 1 || cnt == 2 || cnt == 4) && off + cnt <= BANK_SPAN;
      if (r.action == ACT_READ || r.action == ACT_WRITE) begin
        if (!legal) begin
          rep.access_error = 1'b1;
        end else if (r.action == ACT_READ) begin
          for (int i = 0; i < cnt; i++) begin
            at = off + i;
            rep.read_data |= ((shown(b, at >> 2) >> ((at % 4) * 8)) & 32'hFF) << (i * 8);
          end
        end else begin
          apply_write(b, off, cnt, r.write_data);
        end
      end else if (r.action == ACT_TICK) begin
        advance_frames(r.tick_count);
      end
      rep.irq         = irq_now();
      rep.running     = is_running_now();
      rep.ticks_left  = ticks_to_next_frame();
      rep.frame_total = frames;
      return rep;
    endfunction

    function void note_request(request_t r);
      pending_reports.push_back(compute_report(r));
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %h, got %h", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_result(report_t got);
      report_t want;
      if (pending_reports.size() == 0) begin
        $display("%0t: result with no request pending, got %h", $time, got);
        failures++;
        return;
      end
      want = pending_reports.pop_front();
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("access_error", 32'(want.access_error), 32'(got.access_error));
      compare_field("irq_out", 32'(want.irq), 32'(got.irq));
      compare_field("is_running", 32'(want.running), 32'(got.running));
      compare_field("ticks_to_vsync", want.ticks_left, got.ticks_left);
      compare_field("frame_total", want.frame_total, got.frame_total);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_action;
  logic [1:0]  in_bank;
  logic [7:0]  in_byte_offset;
  logic [2:0]  in_byte_count;
  logic [31:0] in_write_data;
  logic [31:0] in_tick_count;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_read_data;
  logic        out_access_error;
  logic        out_irq_out;
  logic        out_is_running;
  logic [31:0] out_ticks_to_vsync;
  logic [31:0] out_frame_total;
  logic        cfg_wr_en;
  logic [31:0] cfg_frame_period;

  tvo_frame_scoreboard sb;
  int send_left;
  bit send_quiet;
  int recv_left;
  bit recv_quiet;

  tv_output_register_and_vsync_timer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_bank            (in_bank),
    .in_byte_offset     (in_byte_offset),
    .in_byte_count      (in_byte_count),
    .in_write_data      (in_write_data),
    .in_tick_count      (in_tick_count),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_data      (out_read_data),
    .out_access_error   (out_access_error),
    .out_irq_out        (out_irq_out),
    .out_is_running     (out_is_running),
    .out_ticks_to_vsync (out_ticks_to_vsync),
    .out_frame_total    (out_frame_total),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_frame_period   (cfg_frame_period)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // stretches of back-to-back traffic alternate with stretches of random gaps
  function automatic int draw_pause(inout int left, inout bit quiet);
    if (left == 0) begin
      left  = $urandom_range(10, 60);
      quiet = ($urandom_range(0, 3) == 0);
    end
    left--;
    return quiet ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic request_t req(act_t a, bank_t b, int off, int cnt,
                                   logic [31:0] data, logic [31:0] ticks);
    request_t r;
    r.action     = a;
    r.bank       = b;
    r.offset     = 8'(off);
    r.count      = 3'(cnt);
    r.write_data = data;
    r.tick_count = ticks;
    return r;
  endfunction

  function automatic request_t build_random_request(logic [31:0] per);
    request_t r;
    int       pick;
    int       cnt;
    r.action     = ACT_READ;
    r.bank       = bank_t'($urandom_range(0, 2));
    r.offset     = 8'($urandom_range(0, 255));
    r.count      = 3'd4;
    r.write_data = $urandom;
    r.tick_count = $urandom;
    case ($urandom_range(0, 2))
      0:       cnt = 1;
      1:       cnt = 2;
      default: cnt = 4;
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      r.action = ACT_TICK;
      case ($urandom_range(0, 5))
        0:       r.tick_count = $urandom_range(0, 3);
        1:       ;
        2:       r.tick_count = per - $urandom_range(0, 3);
        3:       r.tick_count = per + $urandom_range(0, 3);
        4:       r.tick_count = '1;
        default: r.tick_count = $urandom_range(0, 1000);
      endcase
    end else if (pick < 48) begin
      // run word, mostly keeping the run bit set
      r.action = ACT_WRITE;
      r.count  = 3'(cnt);
      r.offset = 8'($urandom_range(0, 4 - cnt));
      if ($urandom_range(0, 6) != 0) r.write_data |= RUN_FLAG;
      else r.write_data &= ~RUN_FLAG;
    end else if (pick < 58) begin
      r.action = ACT_WRITE;
      r.count  = 3'(cnt);
      if ($urandom_range(0, 1) == 1) begin
        r.bank   = BANK_ENC;
        r.offset = 8'(ENC_STAT_W * 4 + $urandom_range(0, 4 - cnt));
      end else begin
        r.bank   = BANK_MIX;
        r.offset = 8'(MIX_STAT_W * 4 + $urandom_range(0, 4 - cnt));
      end
    end else if (pick < 64) begin
      r.action = ACT_WRITE;
      r.bank   = BANK_ENC;
      r.offset = 8'(ENC_MASK_W * 4);
      if ($urandom_range(0, 2) != 0) r.write_data &= ~MASK_FLAG;
    end else if (pick < 92) begin
      r.action = (pick < 86) ? ACT_READ : ACT_WRITE;
      r.count  = 3'(cnt);
      r.offset = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 15))
                                             : 8'($urandom_range(0, BANK_SPAN - cnt));
    end else begin
      r.action = act_t'($urandom_range(0, 3));
      r.bank   = bank_t'($urandom_range(0, 3));
      r.count  = 3'($urandom_range(0, 7));
    end
    return r;
  endfunction

  task automatic send_request(input request_t r);
    int gap;
    gap = draw_pause(send_left, send_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= r.action;
    in_bank        <= r.bank;
    in_byte_offset <= r.offset;
    in_byte_count  <= r.count;
    in_write_data  <= r.write_data;
    in_tick_count  <= r.tick_count;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_requests();
    in_valid <= 1'b0;
    // one edge so the monitor has noted the last accepted request
    @(posedge clk);
    while (sb.pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_frame_period(input logic [31:0] per);
    cfg_wr_en        <= 1'b1;
    cfg_frame_period <= per;
    sb.frame_period   = per;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // request and result monitor; values seen here are the ones before the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_request(req(act_t'(in_action), bank_t'(in_bank), int'(in_byte_offset),
                            int'(in_byte_count), in_write_data, in_tick_count));
      if (out_valid && out_ready)
        sb.check_result('{read_data: out_read_data, access_error: out_access_error,
                          irq: out_irq_out, running: out_is_running,
                          ticks_left: out_ticks_to_vsync, frame_total: out_frame_total});
    end
  end

  initial begin
    int stall;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_pause(recv_left, recv_quiet);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #2_000_000;
    $display("tv_output_register_and_vsync_timer: mismatch");
    $finish;
  end

  initial begin
    logic [31:0] period_plan [8];
    sb               = new();
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_action        <= '0;
    in_bank          <= '0;
    in_byte_offset   <= '0;
    in_byte_count    <= '0;
    in_write_data    <= '0;
    in_tick_count    <= '0;
    cfg_wr_en        <= 1'b0;
    cfg_frame_period <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed pass under the reset frame period
    send_request(req(ACT_READ,  BANK_CTRL, 0,   4, 32'h0, 32'h0));
    send_request(req(ACT_READ,  BANK_ENC,  ENC_MASK_W * 4, 4, 32'h0, 32'h0));
    send_request(req(ACT_READ,  BANK_BAD,  0,   4, 32'h0, 32'h0));
    send_request(req(ACT_READ,  BANK_CTRL, 0,   3, 32'h0, 32'h0));
    send_request(req(ACT_READ,  BANK_MIX,  253, 4, 32'h0, 32'h0));
    send_request(req(ACT_READ,  BANK_ENC,  255, 1, 32'h0, 32'h0));
    send_request(req(ACT_NONE,  BANK_CTRL, 0,   4, 32'hFFFFFFFF, 32'h5));
    send_request(req(ACT_TICK,  BANK_CTRL, 0,   4, 32'h0, 32'd5));
    send_request(req(ACT_WRITE, BANK_ENC,  ENC_MASK_W * 4, 4, 32'h0, 32'h0));
    send_request(req(ACT_WRITE, BANK_CTRL, 0,   4, 32'hFFFFFFFF, 32'h0));
    send_request(req(ACT_WRITE, BANK_MIX,  0,   1, 32'h1, 32'h0));
    send_request(req(ACT_WRITE, BANK_ENC,  0,   2, 32'h0001, 32'h0));
    send_request(req(ACT_TICK,  BANK_CTRL, 0,   4, 32'h0, 32'd399999));
    send_request(req(ACT_TICK,  BANK_CTRL, 0,   4, 32'h0, 32'd1));
    send_request(req(ACT_READ,  BANK_ENC,  ENC_STAT_W * 4, 4, 32'h0, 32'h0));
    send_request(req(ACT_WRITE, BANK_ENC,  ENC_STAT_W * 4, 4, 32'hFFFFFFFF, 32'h0));
    send_request(req(ACT_TICK,  BANK_CTRL, 0,   4, 32'h0, 32'hFFFFFFFF));
    send_request(req(ACT_READ,  BANK_ENC,  2,   4, 32'h0, 32'h0));
    send_request(req(ACT_WRITE, BANK_MIX,  6,   4, 32'hA5A5A5A5, 32'h0));
    send_request(req(ACT_WRITE, BANK_CTRL, 254, 2, 32'h5A5A, 32'h0));
    send_request(req(ACT_WRITE, BANK_CTRL, 255, 2, 32'h5A5A, 32'h0));
    send_request(req(ACT_WRITE, BANK_CTRL, 0,   1, 32'h0, 32'h0));
    send_request(req(ACT_READ,  BANK_CTRL, 0,   1, 32'h0, 32'h0));
    send_request(req(ACT_WRITE, BANK_CTRL, 0,   1, 32'h1, 32'h0));
    send_request(req(ACT_TICK,  BANK_CTRL, 0,   4, 32'h0, 32'd123456));

    // a short period first, so the phase left over sits above it
    period_plan = '{32'd7, 32'd0, 32'd1, 32'hFFFFFFFF, 32'd400000, 32'd100,
                    32'($urandom_range(2, 5000)), 32'h80000000};
    foreach (period_plan[p]) begin
      drain_requests();
      set_frame_period(period_plan[p]);
      repeat (PHASE_REQS) send_request(build_random_request(sb.frame_period));
    end
    drain_requests();

    if (sb.failures == 0 && sb.pending_reports.size() == 0) begin
      $display("tv_output_register_and_vsync_timer: match");
    end else begin
      $display("tv_output_register_and_vsync_timer: mismatch");
    end
    $finish;
  end

endmodule
